// ===== hw/rtl/ted_pkg.sv =====
// Shared types and constants for the text encoding detector.
`timescale 1ns / 1ps

package ted_pkg;

  // Encoding codes reported with each verdict.
  typedef enum logic [1:0] {
    EncMbcs    = 2'd0,
    EncUtf8    = 2'd1,
    EncUtf16Le = 2'd2,
    EncUtf16Be = 2'd3
  } enc_e;

  // One byte of the buffer, with the end marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // One verdict.
  typedef struct packed {
    enc_e encoding;
    logic has_bom;
  } out_t;

  // Summary of the buffer after the current byte, from tracker to verdict logic.
  typedef struct packed {
    logic bom_utf8;
    logic bom_le;
    logic bom_be;
    logic mbcs_ok;
    logic utf8_ok;
    logic le_ok;
    logic be_ok;
    logic le_pair_seen;
    logic be_pair_seen;
  } ted_sum_t;

  // Byte order mark bytes.
  localparam logic [7:0] Utf8Bom0 = 8'hEF;
  localparam logic [7:0] Utf8Bom1 = 8'hBB;
  localparam logic [7:0] Utf8Bom2 = 8'hBF;
  localparam logic [7:0] BomFf    = 8'hFF;
  localparam logic [7:0] BomFe    = 8'hFE;

  // Surrogate ranges of a 16-bit unit.
  localparam logic [15:0] HiSurLo = 16'hD800;
  localparam logic [15:0] HiSurHi = 16'hDBFF;
  localparam logic [15:0] LoSurLo = 16'hDC00;
  localparam logic [15:0] LoSurHi = 16'hDFFF;

endpackage

// ===== hw/rtl/ted_tracker.sv =====
// Per-buffer state of the detector: BOM capture and the four validators.
`timescale 1ns / 1ps

module ted_tracker import ted_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_t      item_i,
  output ted_sum_t sum_o
);

  typedef struct packed {
    logic ok;
    logic need;
    logic seen;
  } u16_st_t;

  // Surrogate pairing check on one complete 16-bit unit.
  function automatic u16_st_t check_unit(input logic [15:0] w, input u16_st_t st);
    u16_st_t r;
    logic    is_hi;
    logic    is_lo;
    r     = st;
    is_hi = (w >= HiSurLo) && (w <= HiSurHi);
    is_lo = (w >= LoSurLo) && (w <= LoSurHi);
    if (st.ok) begin
      if (w == 16'h0000) begin
        r.ok = 1'b0;
      end else if (st.need) begin
        if (is_lo) r.need = 1'b0;
        else r.ok = 1'b0;
      end else if (is_hi) begin
        r.need = 1'b1;
        r.seen = 1'b1;
      end else if (is_lo) begin
        r.ok = 1'b0;
      end
    end
    return r;
  endfunction

  localparam u16_st_t U16Reset = '{ok: 1'b1, need: 1'b0, seen: 1'b0};

  logic [1:0] pos_q, pos_d;
  logic [7:0] fb0_q, fb0_d, fb1_q, fb1_d;
  logic       u8bom_q, u8bom_d;
  logic [7:0] held_q, held_d;
  logic       odd_q, odd_d;
  logic       nz_q, nz_d;
  logic       u8ok_q, u8ok_d;
  logic [2:0] due_q, due_d;
  u16_st_t    le_q, le_d, be_q, be_d;
  logic [7:0] b;

  assign b = item_i.data_byte;

  // Next state after the current byte.
  always_comb begin
    pos_d   = (pos_q == 2'd3) ? pos_q : pos_q + 2'd1;
    fb0_d   = (pos_q == 2'd0) ? b : fb0_q;
    fb1_d   = (pos_q == 2'd1) ? b : fb1_q;
    u8bom_d = u8bom_q | ((pos_q == 2'd2) && (fb0_q == Utf8Bom0) &&
                         (fb1_q == Utf8Bom1) && (b == Utf8Bom2));
    nz_d    = nz_q & (b != 8'h00);

    // UTF-8 lead and continuation structure.
    u8ok_d = u8ok_q;
    due_d  = due_q;
    if (u8ok_q) begin
      if (due_q != 3'd0) begin
        if (b[7:6] != 2'b10) u8ok_d = 1'b0;
        else due_d = due_q - 3'd1;
      end else if (b == 8'h00) begin
        u8ok_d = 1'b0;
      end else begin
        case (1'b1)
          (b[7] == 1'b0):          due_d = 3'd0;
          (b[7:5] == 3'b110):      due_d = 3'd1;
          (b[7:4] == 4'b1110):     due_d = 3'd2;
          (b[7:3] == 5'b11110):    due_d = 3'd3;
          (b[7:2] == 6'b111110):   due_d = 3'd4;
          (b[7:1] == 7'b1111110):  due_d = 3'd5;
          default:                 due_d = 3'd0;
        endcase
      end
    end

    // UTF-16 pairing, one unit every second byte.
    held_d = held_q;
    le_d   = le_q;
    be_d   = be_q;
    if (!odd_q) begin
      held_d = b;
      odd_d  = 1'b1;
    end else begin
      le_d  = check_unit({b, held_q}, le_q);
      be_d  = check_unit({held_q, b}, be_q);
      odd_d = 1'b0;
    end
  end

  // Summary of the buffer including the current byte.
  always_comb begin
    sum_o.bom_utf8     = u8bom_d;
    sum_o.bom_le       = (pos_q != 2'd0) && (fb0_d == BomFf) && (fb1_d == BomFe);
    sum_o.bom_be       = (pos_q != 2'd0) && (fb0_d == BomFe) && (fb1_d == BomFf);
    sum_o.mbcs_ok      = nz_d;
    sum_o.utf8_ok      = u8ok_d && (due_d == 3'd0);
    sum_o.le_ok        = le_d.ok && !le_d.need && !odd_d;
    sum_o.be_ok        = be_d.ok && !be_d.need && !odd_d;
    sum_o.le_pair_seen = le_d.seen;
    sum_o.be_pair_seen = be_d.seen;
  end

  // State registers; the last byte of a buffer returns everything to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 2'd0;
      fb0_q   <= 8'h00;
      fb1_q   <= 8'h00;
      u8bom_q <= 1'b0;
      held_q  <= 8'h00;
      odd_q   <= 1'b0;
      nz_q    <= 1'b1;
      u8ok_q  <= 1'b1;
      due_q   <= 3'd0;
      le_q    <= U16Reset;
      be_q    <= U16Reset;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        pos_q   <= 2'd0;
        fb0_q   <= 8'h00;
        fb1_q   <= 8'h00;
        u8bom_q <= 1'b0;
        held_q  <= 8'h00;
        odd_q   <= 1'b0;
        nz_q    <= 1'b1;
        u8ok_q  <= 1'b1;
        due_q   <= 3'd0;
        le_q    <= U16Reset;
        be_q    <= U16Reset;
      end else begin
        pos_q   <= pos_d;
        fb0_q   <= fb0_d;
        fb1_q   <= fb1_d;
        u8bom_q <= u8bom_d;
        held_q  <= held_d;
        odd_q   <= odd_d;
        nz_q    <= nz_d;
        u8ok_q  <= u8ok_d;
        due_q   <= due_d;
        le_q    <= le_d;
        be_q    <= be_d;
      end
    end
  end

  // The UTF-16 phase follows the byte count over the first bytes.
  a_phase_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pos_q == 2'd1) |-> odd_q) and ((pos_q == 2'd0 || pos_q == 2'd2) |-> !odd_q))
    else $error("UTF-16 phase out of step with byte position");

  // No UTF-8 lead asks for more than five continuation bytes.
  a_due_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    due_q <= 3'd5)
    else $error("continuation count out of range");

  // A buffer's last byte leaves the tracker in its reset state.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.last_byte) |=> (pos_q == 2'd0 && !odd_q && nz_q && u8ok_q))
    else $error("state not cleared after a verdict");

endmodule

// ===== hw/rtl/ted_verdict.sv =====
// Combines BOM detection and validator results into one verdict.
`timescale 1ns / 1ps

module ted_verdict import ted_pkg::*; (
  input  ted_sum_t sum_i,
  output out_t     verdict_o
);

  logic [2:0] pass_cnt;

  assign pass_cnt = {2'b00, sum_i.mbcs_ok} + {2'b00, sum_i.utf8_ok} +
                    {2'b00, sum_i.le_ok} + {2'b00, sum_i.be_ok};

  // A BOM wins; otherwise the validators decide.
  always_comb begin
    verdict_o.has_bom  = 1'b0;
    verdict_o.encoding = EncMbcs;
    if (sum_i.bom_utf8) begin
      verdict_o.encoding = EncUtf8;
      verdict_o.has_bom  = 1'b1;
    end else if (sum_i.bom_le) begin
      verdict_o.encoding = EncUtf16Le;
      verdict_o.has_bom  = 1'b1;
    end else if (sum_i.bom_be) begin
      verdict_o.encoding = EncUtf16Be;
      verdict_o.has_bom  = 1'b1;
    end else if (pass_cnt == 3'd1) begin
      if (sum_i.utf8_ok)    verdict_o.encoding = EncUtf8;
      else if (sum_i.le_ok) verdict_o.encoding = EncUtf16Le;
      else if (sum_i.be_ok) verdict_o.encoding = EncUtf16Be;
      else                  verdict_o.encoding = EncMbcs;
    end else if (pass_cnt > 3'd1) begin
      // Both UTF-16 readings fit and UTF-8 does not: the surrogate pairs decide.
      if (sum_i.le_ok && sum_i.be_ok && !sum_i.utf8_ok) begin
        verdict_o.encoding = (sum_i.be_pair_seen && !sum_i.le_pair_seen) ?
                             EncUtf16Be : EncUtf16Le;
      end else begin
        verdict_o.encoding = EncUtf8;
      end
    end
  end

endmodule

// ===== hw/rtl/text_encoding_detector.sv =====
// Top level of the text encoding detector: input register, tracker, verdict register.
//
// Usage: bytes of a text buffer arrive in order on the input channel
// (in_valid_i / in_ready_o / in_i), the final byte marked by last_byte.
// After that byte one verdict leaves on the output channel
// (out_valid_o / out_ready_i / out_o): encoding (MBCS, UTF-8, UTF-16LE,
// UTF-16BE) and a flag for a byte order mark. Other bytes give no output.
// Throughput: one byte per cycle, including directly after a last byte, while
// no stalled verdict backs up the input; the next buffer can start in the
// cycle after the previous one ends. A last byte passes through one input
// register; its verdict then loads into the result register.
// The per-byte state update and the verdict logic sit between those two
// registers and set the cycle time.
// Reset clears both registers' valid flags and all buffer state, so the
// first byte after reset starts a new buffer.
// When the receiver stalls, the verdict holds in the result register and
// the input register still fills; in_ready_o drops only when both are
// occupied and the result is not being taken.
`timescale 1ns / 1ps

module text_encoding_detector import ted_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic     s1_valid_q;
  in_t      s1_q;
  logic     out_valid_q;
  out_t     out_q;
  logic     advance;
  logic     step;
  ted_sum_t sum;
  out_t     verdict;

  // The result register can load when it is empty or being emptied.
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_i;
    end
  end

  ted_tracker u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (s1_q),
    .sum_o  (sum)
  );

  ted_verdict u_verdict (
    .sum_i     (sum),
    .verdict_o (verdict)
  );

  // Result register: loads a verdict on each buffer's last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && s1_q.last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && s1_q.last_byte) begin
      out_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A stalled verdict stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_o)))
    else $error("verdict changed while stalled");

  // With no verdict pending the block always takes a byte.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  // A verdict appears only after a last byte moved on from the input register.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_q.last_byte))
    else $error("verdict without a last byte");

endmodule

// ===== verif/tb_text_encoding_detector.sv =====
// Self-checking testbench for the text encoding detector: byte driver, verdict monitor, predictor.
`timescale 1ns / 1ps

module tb_text_encoding_detector;
  import ted_pkg::*;

  // One queued byte, optionally held back until every verdict has arrived.
  typedef struct packed {
    in_t  item;
    logic drain;
  } pend_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  in_t  in_pl = '0;
  logic out_ready = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_o;

  pend_t       pend_q[$];
  out_t        verdict_q[$];
  logic [7:0]  bytes_q[$];
  int          send_idle = 23;
  int          recv_idle = 86;
  int          err_cnt = 0;
  int          queued = 0;
  bit          drain_next = 1'b0;
  int          stall_req = 0;
  int          stall_taken = 0;
  int          hold_left = 0;
  out_t        pred_v;
  out_t        exp_v;
  pend_t       nxt_item;

  // Predictor state for the buffer in progress.
  logic [1:0]  head_cnt;
  logic [7:0]  lead0, lead1, held;
  logic        bom8_hit, half_unit, nz_ok, u8_ok;
  logic [2:0]  u8_tail;
  logic        le_valid, le_wait_lo, le_pair;
  logic        be_valid, be_wait_lo, be_pair;

  text_encoding_detector uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_i        (in_pl),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_o       (out_o)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Start a fresh buffer in the predictor.
  function automatic void clear_tracker();
    head_cnt = 2'd0;
    lead0 = 8'h00;
    lead1 = 8'h00;
    held = 8'h00;
    bom8_hit = 1'b0;
    half_unit = 1'b0;
    nz_ok = 1'b1;
    u8_ok = 1'b1;
    u8_tail = 3'd0;
    le_valid = 1'b1;
    le_wait_lo = 1'b0;
    le_pair = 1'b0;
    be_valid = 1'b1;
    be_wait_lo = 1'b0;
    be_pair = 1'b0;
  endfunction

  // Surrogate pairing of one 16-bit unit; state is {ok, waiting for low, pair seen}.
  function automatic logic [2:0] surr_step(logic [15:0] w, logic [2:0] st);
    logic ok, wt, pr, hi, lo;
    {ok, wt, pr} = st;
    hi = (w >= HiSurLo) && (w <= HiSurHi);
    lo = (w >= LoSurLo) && (w <= LoSurHi);
    if (ok) begin
      if (w == 16'h0000) begin
        ok = 1'b0;
      end else if (wt) begin
        if (lo) wt = 1'b0;
        else ok = 1'b0;
      end else if (hi) begin
        wt = 1'b1;
        pr = 1'b1;
      end else if (lo) begin
        ok = 1'b0;
      end
    end
    return {ok, wt, pr};
  endfunction

  // Fold one byte into the predictor; returns 1 with the verdict on a last byte.
  function automatic bit absorb_byte(in_t it, output out_t v);
    logic [7:0] b;
    logic [1:0] pos;
    logic       mb, u8, le, be;
    int         hits;
    b = it.data_byte;
    pos = head_cnt;
    v = '0;
    if (pos == 2'd0) lead0 = b;
    if (pos == 2'd1) lead1 = b;
    if (pos == 2'd2 && lead0 == Utf8Bom0 && lead1 == Utf8Bom1 && b == Utf8Bom2) bom8_hit = 1'b1;
    if (head_cnt != 2'd3) head_cnt = head_cnt + 2'd1;
    if (b == 8'h00) nz_ok = 1'b0;

    // UTF-8 lead and continuation structure.
    if (u8_ok) begin
      if (u8_tail != 3'd0) begin
        if (b[7:6] != 2'b10) u8_ok = 1'b0;
        else u8_tail = u8_tail - 3'd1;
      end else if (b == 8'h00) begin
        u8_ok = 1'b0;
      end else if (b[7] == 1'b0) begin
        u8_tail = 3'd0;
      end else if (b[7:5] == 3'b110) begin
        u8_tail = 3'd1;
      end else if (b[7:4] == 4'b1110) begin
        u8_tail = 3'd2;
      end else if (b[7:3] == 5'b11110) begin
        u8_tail = 3'd3;
      end else if (b[7:2] == 6'b111110) begin
        u8_tail = 3'd4;
      end else if (b[7:1] == 7'b1111110) begin
        u8_tail = 3'd5;
      end else begin
        u8_tail = 3'd0;
      end
    end

    // UTF-16 units in both byte orders.
    if (!half_unit) begin
      held = b;
      half_unit = 1'b1;
    end else begin
      {le_valid, le_wait_lo, le_pair} = surr_step({b, held}, {le_valid, le_wait_lo, le_pair});
      {be_valid, be_wait_lo, be_pair} = surr_step({held, b}, {be_valid, be_wait_lo, be_pair});
      half_unit = 1'b0;
    end

    if (!it.last_byte) return 1'b0;

    // Verdict: byte order marks first, then the validators combined.
    if (bom8_hit) begin
      v.encoding = EncUtf8;
      v.has_bom = 1'b1;
    end else if (pos != 2'd0 && lead0 == BomFf && lead1 == BomFe) begin
      v.encoding = EncUtf16Le;
      v.has_bom = 1'b1;
    end else if (pos != 2'd0 && lead0 == BomFe && lead1 == BomFf) begin
      v.encoding = EncUtf16Be;
      v.has_bom = 1'b1;
    end else begin
      mb = nz_ok;
      u8 = u8_ok && (u8_tail == 3'd0);
      le = le_valid && !le_wait_lo && !half_unit;
      be = be_valid && !be_wait_lo && !half_unit;
      hits = int'(mb) + int'(u8) + int'(le) + int'(be);
      if (hits == 1) begin
        if (u8) v.encoding = EncUtf8;
        else if (le) v.encoding = EncUtf16Le;
        else if (be) v.encoding = EncUtf16Be;
        else v.encoding = EncMbcs;
      end else if (hits > 1) begin
        if (le && be && !u8) v.encoding = (be_pair && !le_pair) ? EncUtf16Be : EncUtf16Le;
        else v.encoding = EncUtf8;
      end else begin
        v.encoding = EncMbcs;
      end
    end
    clear_tracker();
    return 1'b1;
  endfunction

  task automatic report_err(string msg);
    err_cnt++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Move the scratch buffer into the send queue, marking its final byte.
  task automatic flush_buffer();
    pend_t p;
    for (int i = 0; i < bytes_q.size(); i++) begin
      p.item.data_byte = bytes_q[i];
      p.item.last_byte = (i == bytes_q.size() - 1);
      p.drain = drain_next;
      drain_next = 1'b0;
      pend_q.push_back(p);
      queued++;
    end
    bytes_q.delete();
  endtask

  // One UTF-8 character, including the tolerated oddities.
  task automatic add_utf8_char();
    logic [7:0] lead;
    int         tail;
    tail = 0;
    case ($urandom_range(0, 9))
      0, 1, 2: lead = 8'($urandom_range(1, 127));
      3: begin lead = {3'b110, 5'($urandom)}; tail = 1; end
      4: begin lead = {4'b1110, 4'($urandom)}; tail = 2; end
      5: begin lead = {5'b11110, 3'($urandom)}; tail = 3; end
      6: begin lead = {6'b111110, 2'($urandom)}; tail = 4; end
      7: begin lead = {7'b1111110, 1'($urandom)}; tail = 5; end
      8: lead = {2'b10, 6'($urandom)};
      default: lead = $urandom_range(0, 1) ? 8'hFE : 8'hFF;
    endcase
    bytes_q.push_back(lead);
    repeat (tail) bytes_q.push_back({2'b10, 6'($urandom)});
  endtask

  task automatic add_unit(bit big_end, logic [15:0] w);
    if (big_end) begin
      bytes_q.push_back(w[15:8]);
      bytes_q.push_back(w[7:0]);
    end else begin
      bytes_q.push_back(w[7:0]);
      bytes_q.push_back(w[15:8]);
    end
  endtask

  // One UTF-16 character: plain unit, narrow text unit or surrogate pair.
  task automatic add_utf16_char(bit big_end);
    logic [15:0] w;
    case ($urandom_range(0, 3))
      0: begin
        add_unit(big_end, {6'b110110, 10'($urandom)});
        add_unit(big_end, {6'b110111, 10'($urandom)});
      end
      1: add_unit(big_end, {8'h00, 8'($urandom_range(1, 255))});
      default: begin
        w = 16'($urandom);
        if (w[15:11] == 5'b11011) w[15] = 1'b0;
        if (w == 16'h0000) w = 16'h0041;
        add_unit(big_end, w);
      end
    endcase
  endtask

  // A random buffer: mostly well-formed text of some kind, sometimes damaged.
  task automatic make_random_buffer();
    int kind, n, idx;
    logic [7:0] picks[10];
    picks = '{8'h00, 8'hFF, 8'hFE, 8'hEF, 8'hBB, 8'hD8, 8'hDC, 8'h80, 8'hFC, 8'h41};
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        n = $urandom_range(1, 6);
        repeat (n) add_utf8_char();
      end
      3, 4, 5: begin
        n = $urandom_range(1, 4);
        repeat (n) add_utf16_char(kind == 5);
      end
      6: begin
        case ($urandom_range(0, 3))
          0: bytes_q = '{Utf8Bom0, Utf8Bom1, Utf8Bom2};
          1: bytes_q = '{BomFf, BomFe};
          2: bytes_q = '{BomFe, BomFf};
          default: bytes_q = '{Utf8Bom0, Utf8Bom1, 8'($urandom)};
        endcase
        n = $urandom_range(0, 3);
        repeat (n) bytes_q.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
      end
      7: begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        repeat (n) bytes_q.push_back(8'($urandom));
      end
      8: begin
        n = $urandom_range(1, 8);
        repeat (n) bytes_q.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
      end
      default: begin
        n = $urandom_range(1, 2);
        repeat (n) bytes_q.push_back(picks[$urandom_range(0, 9)]);
      end
    endcase
    // Occasional damage: overwrite, truncate or extend by one byte.
    if (kind <= 5 && $urandom_range(0, 99) < 15) begin
      idx = $urandom_range(0, bytes_q.size() - 1);
      case ($urandom_range(0, 2))
        0: bytes_q[idx] = 8'($urandom);
        1: if (bytes_q.size() > 1) void'(bytes_q.pop_back());
        default: bytes_q.push_back(8'($urandom));
      endcase
    end
    flush_buffer();
  endtask

  task automatic fill_phase(int target);
    int start;
    start = queued;
    while (queued - start < target) make_random_buffer();
  endtask

  // Driver: predict on each transfer, then offer the next byte or idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        if (absorb_byte(in_pl, pred_v)) verdict_q.push_back(pred_v);
      end
      if (!in_valid || in_ready_o) begin
        if (pend_q.size() != 0 && (!pend_q[0].drain || verdict_q.size() == 0) &&
            $urandom_range(0, 99) >= send_idle) begin
          nxt_item = pend_q.pop_front();
          in_pl <= nxt_item.item;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each verdict transfer, then choose the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_err($sformatf("verdict enc=%0d bom=%0d with none pending",
                             out_o.encoding, out_o.has_bom));
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_o.encoding !== exp_v.encoding)
          report_err($sformatf("encoding got %0d want %0d", out_o.encoding, exp_v.encoding));
        if (out_o.has_bom !== exp_v.has_bom)
          report_err($sformatf("has_bom got %0d want %0d", out_o.has_bom, exp_v.has_bom));
      end
    end
    // A requested long hold-off lets the block back up into its input.
    if (stall_req != stall_taken) begin
      stall_taken = stall_req;
      hold_left = 60;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Stimulus and end of run.
  initial begin
    clear_tracker();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed buffers: each mark, each verdict, surrogate tie-breaks, cut-off lead.
    bytes_q = '{8'hEF, 8'hBB, 8'hBF};
    flush_buffer();
    bytes_q = '{8'hFF, 8'hFE};
    flush_buffer();
    bytes_q = '{8'hFE, 8'hFF};
    flush_buffer();
    bytes_q = '{8'h00};
    flush_buffer();
    bytes_q = '{8'hFF};
    flush_buffer();
    bytes_q = '{8'hD8, 8'h00, 8'hDC, 8'h00};
    flush_buffer();
    bytes_q = '{8'h00, 8'hD8, 8'h00, 8'hDC};
    flush_buffer();
    bytes_q = '{8'hC3};
    flush_buffer();
    bytes_q = '{8'hFC, 8'h80, 8'hBF, 8'h80, 8'hBF, 8'h80};
    flush_buffer();

    // Busy receiver, mostly steady sender.
    fill_phase(600);
    while (pend_q.size() != 0) @(negedge clk_i);

    // Swap the idling; the first byte waits until all verdicts are out.
    send_idle = 86;
    recv_idle = 23;
    drain_next = 1'b1;
    fill_phase(600);
    while (pend_q.size() != 0) @(negedge clk_i);

    // Full rate both sides, with one long receiver hold-off at the start.
    send_idle = 0;
    recv_idle = 0;
    stall_req++;
    fill_phase(600);

    while (pend_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("tb_text_encoding_detector: done, clean");
    end else begin
      $display("tb_text_encoding_detector: done, errors");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("tb_text_encoding_detector: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ted_pkg.sv
hw/rtl/ted_tracker.sv
hw/rtl/ted_verdict.sv
hw/rtl/text_encoding_detector.sv
verif/tb_text_encoding_detector.sv
